>>> rtl/window_3x3_line_buffer_macros.svh
// Assertion macros shared by the checker of the 3x3 window line buffer.
`ifndef WINDOW_3X3_LINE_BUFFER_MACROS_SVH
`define WINDOW_3X3_LINE_BUFFER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WLB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WLB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/wlb_pkg.sv
// Shared constants, register codes and structs of the 3x3 window line buffer.
`timescale 1ns / 1ps

package wlb_pkg;

  localparam int MAX_WIDTH    = 256;
  localparam int CHANNELS     = 4;
  localparam int CHANNEL_BITS = 8;

  // One row bank holds a full padded row
  localparam int ROW_STRIDE = MAX_WIDTH + 2;
  localparam int COL_W      = $clog2(ROW_STRIDE);

  localparam int PIXEL_W    = 32;
  localparam int PIXEL_BITS = CHANNELS * CHANNEL_BITS;
  localparam logic [PIXEL_W-1:0] PIXEL_MASK =
    (PIXEL_BITS >= PIXEL_W) ? {PIXEL_W{1'b1}} : PIXEL_W'((64'd1 << PIXEL_BITS) - 64'd1);

  localparam int HEIGHT_W     = 11;
  localparam int WIDTH_W      = 9;
  localparam int GROUP_W      = 9;
  localparam int ROW_W        = 11;
  localparam int FRAME_W      = 8;
  localparam int SEL_W        = 2;
  localparam int HEIGHT_LIMIT = 1024;
  localparam int GROUP_LIMIT  = 256;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(8);
  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(8);
  localparam logic [GROUP_W-1:0]  GROUP_RESET  = GROUP_W'(1);

  // Row bank codes
  localparam logic [SEL_W-1:0] BANK_0 = 2'd0;
  localparam logic [SEL_W-1:0] BANK_1 = 2'd1;
  localparam logic [SEL_W-1:0] BANK_2 = 2'd2;
  localparam int NUM_BANKS = 3;

  typedef enum logic [1:0] {
    REG_HEIGHT = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_GROUP  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [HEIGHT_W-1:0] height;
    logic [WIDTH_W-1:0]  width;
    logic [GROUP_W-1:0]  group_count;
  } cfg_t;

  // Per-beat control from the position counters
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [SEL_W-1:0] sel;
    logic             emit;
    logic             frame_last;
    logic             run_last;
  } item_ctrl_t;

  typedef logic [NUM_BANKS-1:0][PIXEL_W-1:0] bank_data_t;

endpackage

>>> rtl/wlb_regs.sv
// APB configuration registers of the 3x3 window line buffer.
`timescale 1ns / 1ps

module wlb_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [wlb_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [wlb_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [wlb_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  output wlb_pkg::cfg_t                     cfg_o
);

  wlb_pkg::cfg_t      cfg_q;
  logic               wr_en;
  wlb_pkg::reg_idx_e  idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = wlb_pkg::reg_idx_e'(paddr[3:2]);

  // Write the addressed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.height      <= wlb_pkg::HEIGHT_RESET;
      cfg_q.width       <= wlb_pkg::WIDTH_RESET;
      cfg_q.group_count <= wlb_pkg::GROUP_RESET;
    end else if (wr_en) begin
      case (idx)
        wlb_pkg::REG_HEIGHT: cfg_q.height      <= pwdata[wlb_pkg::HEIGHT_W-1:0];
        wlb_pkg::REG_WIDTH:  cfg_q.width       <= pwdata[wlb_pkg::WIDTH_W-1:0];
        wlb_pkg::REG_GROUP:  cfg_q.group_count <= pwdata[wlb_pkg::GROUP_W-1:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    case (idx)
      wlb_pkg::REG_HEIGHT: prdata = wlb_pkg::APB_DATA_W'(cfg_q.height);
      wlb_pkg::REG_WIDTH:  prdata = wlb_pkg::APB_DATA_W'(cfg_q.width);
      wlb_pkg::REG_GROUP:  prdata = wlb_pkg::APB_DATA_W'(cfg_q.group_count);
      default:             prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/wlb_ctrl.sv
// Column, row, bank and frame counters of the 3x3 window line buffer.
`timescale 1ns / 1ps

module wlb_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  wlb_pkg::cfg_t        cfg_i,
  output wlb_pkg::item_ctrl_t  item_o
);

  localparam int CW = wlb_pkg::COL_W;

  logic [CW-1:0]                 col_q, col_d;
  logic [wlb_pkg::ROW_W-1:0]     row_q, row_d;
  logic [wlb_pkg::SEL_W-1:0]     sel_q, sel_d;
  logic [wlb_pkg::FRAME_W-1:0]   frame_q, frame_d;

  logic [CW:0]                   cols;
  logic [CW:0]                   col_inc;
  logic [wlb_pkg::ROW_W:0]       rows;
  logic [wlb_pkg::ROW_W:0]       row_inc;
  logic [wlb_pkg::GROUP_W-1:0]   groups;
  logic [wlb_pkg::FRAME_W:0]     frame_inc;
  logic                          col_end;
  logic                          row_end;
  logic                          run_end;

  // Clamp the frame geometry to what the banks and counters hold
  assign cols = (32'(cfg_i.width) > 32'(wlb_pkg::MAX_WIDTH))
              ? (CW+1)'(wlb_pkg::MAX_WIDTH + 2)
              : (CW+1)'(cfg_i.width) + (CW+1)'(2);
  assign rows = (32'(cfg_i.height) > 32'(wlb_pkg::HEIGHT_LIMIT))
              ? (wlb_pkg::ROW_W+1)'(wlb_pkg::HEIGHT_LIMIT + 2)
              : (wlb_pkg::ROW_W+1)'(cfg_i.height) + (wlb_pkg::ROW_W+1)'(2);
  always_comb begin
    if (cfg_i.group_count == '0) begin
      groups = wlb_pkg::GROUP_W'(1);
    end else if (32'(cfg_i.group_count) > 32'(wlb_pkg::GROUP_LIMIT)) begin
      groups = wlb_pkg::GROUP_W'(wlb_pkg::GROUP_LIMIT);
    end else begin
      groups = cfg_i.group_count;
    end
  end

  assign col_inc   = {1'b0, col_q} + (CW+1)'(1);
  assign row_inc   = {1'b0, row_q} + (wlb_pkg::ROW_W+1)'(1);
  assign frame_inc = {1'b0, frame_q} + (wlb_pkg::FRAME_W+1)'(1);
  assign col_end   = col_inc >= cols;
  assign row_end   = row_inc >= rows;
  assign run_end   = frame_inc >= (wlb_pkg::FRAME_W+1)'(groups);

  // Describe the current beat
  assign item_o.col        = col_q;
  assign item_o.sel        = sel_q;
  assign item_o.emit       = (row_q > wlb_pkg::ROW_W'(1)) && (col_q > CW'(1));
  assign item_o.frame_last = col_end && row_end;
  assign item_o.run_last   = col_end && row_end && run_end;

  // Advance the position after each accepted beat
  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    sel_d   = sel_q;
    frame_d = frame_q;
    if (accept_i) begin
      if (!col_end) begin
        col_d = col_inc[CW-1:0];
      end else begin
        col_d = '0;
        if (row_end) begin
          row_d   = '0;
          sel_d   = wlb_pkg::BANK_0;
          frame_d = run_end ? '0 : frame_inc[wlb_pkg::FRAME_W-1:0];
        end else begin
          row_d = row_inc[wlb_pkg::ROW_W-1:0];
          sel_d = (sel_q == wlb_pkg::BANK_2) ? wlb_pkg::BANK_0 : sel_q + wlb_pkg::SEL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      sel_q   <= wlb_pkg::BANK_0;
      frame_q <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      sel_q   <= sel_d;
      frame_q <= frame_d;
    end
  end

endmodule

>>> rtl/wlb_row_mem.sv
// One row bank: a padded row of pixels with one write port and one registered read port.
`timescale 1ns / 1ps

module wlb_row_mem (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic [wlb_pkg::COL_W-1:0]     wr_addr_i,
  input  logic [wlb_pkg::PIXEL_W-1:0]   wr_data_i,
  input  logic                          rd_en_i,
  input  logic [wlb_pkg::COL_W-1:0]     rd_addr_i,
  output logic [wlb_pkg::PIXEL_W-1:0]   rd_data_o
);

  logic [wlb_pkg::PIXEL_W-1:0] mem_q [wlb_pkg::ROW_STRIDE];
  logic [wlb_pkg::PIXEL_W-1:0] rd_data_q;

  // Store the incoming pixel
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read and hold until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/wlb_window.sv
// Window stage: column shift registers, window assembly and the output register.
`timescale 1ns / 1ps

module wlb_window (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  logic [wlb_pkg::PIXEL_W-1:0]   pixel_i,
  input  wlb_pkg::item_ctrl_t           item_i,
  input  wlb_pkg::bank_data_t           bank_data_i,
  output logic                          busy_o,
  input  logic                          stall_i,
  output logic                          valid_o,
  output logic [wlb_pkg::PIXEL_W-1:0]   top_left_o,
  output logic [wlb_pkg::PIXEL_W-1:0]   top_mid_o,
  output logic [wlb_pkg::PIXEL_W-1:0]   top_right_o,
  output logic [wlb_pkg::PIXEL_W-1:0]   mid_left_o,
  output logic [wlb_pkg::PIXEL_W-1:0]   centre_o,
  output logic [wlb_pkg::PIXEL_W-1:0]   mid_right_o,
  output logic [wlb_pkg::PIXEL_W-1:0]   bottom_left_o,
  output logic [wlb_pkg::PIXEL_W-1:0]   bottom_mid_o,
  output logic [wlb_pkg::PIXEL_W-1:0]   bottom_right_o,
  output logic                          frame_last_o,
  output logic                          run_last_o
);

  localparam int PW = wlb_pkg::PIXEL_W;

  // Stage holding the beat whose bank reads are in flight
  logic                       a_valid_q;
  logic [PW-1:0]              a_px_q;
  logic [wlb_pkg::SEL_W-1:0]  a_sel_q;
  logic                       a_emit_q;
  logic                       a_frame_last_q;
  logic                       a_run_last_q;

  logic [PW-1:0]              lc_q [6];
  logic [PW-1:0]              top_px;
  logic [PW-1:0]              mid_px;

  logic                       o_valid_q;
  logic [PW-1:0]              o_px_q [9];
  logic                       o_frame_last_q;
  logic                       o_run_last_q;

  logic                       o_free;
  logic                       a_go;

  assign o_free = !o_valid_q || !stall_i;
  assign a_go   = a_valid_q && (!a_emit_q || o_free);
  assign busy_o = a_valid_q && !a_go;

  // Pick the two older rows relative to the bank being written
  always_comb begin
    case (a_sel_q)
      wlb_pkg::BANK_0: begin
        top_px = bank_data_i[1];
        mid_px = bank_data_i[2];
      end
      wlb_pkg::BANK_1: begin
        top_px = bank_data_i[2];
        mid_px = bank_data_i[0];
      end
      wlb_pkg::BANK_2: begin
        top_px = bank_data_i[0];
        mid_px = bank_data_i[1];
      end
      default: begin
        top_px = bank_data_i[1];
        mid_px = bank_data_i[2];
      end
    endcase
  end

  // Track occupancy of both stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (load_i) begin
        a_valid_q <= 1'b1;
      end else if (a_go) begin
        a_valid_q <= 1'b0;
      end
      if (a_go && a_emit_q) begin
        o_valid_q <= 1'b1;
      end else if (!stall_i) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  // Capture the accepted beat
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      a_px_q         <= pixel_i;
      a_sel_q        <= item_i.sel;
      a_emit_q       <= item_i.emit;
      a_frame_last_q <= item_i.frame_last;
      a_run_last_q   <= item_i.run_last;
    end
  end

  // Shift the left columns of every window row
  always_ff @(posedge clk_i) begin
    if (a_go) begin
      lc_q[0] <= lc_q[1];
      lc_q[1] <= top_px;
      lc_q[2] <= lc_q[3];
      lc_q[3] <= mid_px;
      lc_q[4] <= lc_q[5];
      lc_q[5] <= a_px_q;
    end
  end

  // Load the window into the output register
  always_ff @(posedge clk_i) begin
    if (a_go && a_emit_q) begin
      o_px_q[0]      <= lc_q[0];
      o_px_q[1]      <= lc_q[1];
      o_px_q[2]      <= top_px;
      o_px_q[3]      <= lc_q[2];
      o_px_q[4]      <= lc_q[3];
      o_px_q[5]      <= mid_px;
      o_px_q[6]      <= lc_q[4];
      o_px_q[7]      <= lc_q[5];
      o_px_q[8]      <= a_px_q;
      o_frame_last_q <= a_frame_last_q;
      o_run_last_q   <= a_run_last_q;
    end
  end

  assign valid_o        = o_valid_q;
  assign top_left_o     = o_px_q[0];
  assign top_mid_o      = o_px_q[1];
  assign top_right_o    = o_px_q[2];
  assign mid_left_o     = o_px_q[3];
  assign centre_o       = o_px_q[4];
  assign mid_right_o    = o_px_q[5];
  assign bottom_left_o  = o_px_q[6];
  assign bottom_mid_o   = o_px_q[7];
  assign bottom_right_o = o_px_q[8];
  assign frame_last_o   = o_frame_last_q;
  assign run_last_o     = o_run_last_q;

endmodule

>>> rtl/window_3x3_line_buffer.sv
// Top level of the 3x3 sliding window line buffer.
// Takes one padded pixel per cycle in raster order while stall_o is low and,
// from padded row 2 and column 2 on, emits one 3x3 window per pixel, top row
// oldest, bottom_right the pixel itself; pixels without a window give no
// output beat. Throughput is one pixel per cycle while not stalled, with no
// bubbles at row or frame ends; a window passes through the registered read of
// the three row banks (MAX_WIDTH+2 pixels each, one write and one read per
// cycle) and then through the output register. stall_o rises only while the
// output register is full and stalled and a window is waiting behind it. The
// banks need no clearing after reset. Registers (APB): height at 0x0, width at
// 0x4, group_count at 0x8; change them only between runs.
`timescale 1ns / 1ps

module window_3x3_line_buffer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [wlb_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [wlb_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [wlb_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  input  logic                              valid_i,
  output logic                              stall_o,
  input  logic [wlb_pkg::PIXEL_W-1:0]       pixel_i,
  output logic                              valid_o,
  input  logic                              stall_i,
  output logic [wlb_pkg::PIXEL_W-1:0]       top_left_o,
  output logic [wlb_pkg::PIXEL_W-1:0]       top_mid_o,
  output logic [wlb_pkg::PIXEL_W-1:0]       top_right_o,
  output logic [wlb_pkg::PIXEL_W-1:0]       mid_left_o,
  output logic [wlb_pkg::PIXEL_W-1:0]       centre_o,
  output logic [wlb_pkg::PIXEL_W-1:0]       mid_right_o,
  output logic [wlb_pkg::PIXEL_W-1:0]       bottom_left_o,
  output logic [wlb_pkg::PIXEL_W-1:0]       bottom_mid_o,
  output logic [wlb_pkg::PIXEL_W-1:0]       bottom_right_o,
  output logic                              frame_last_o,
  output logic                              run_last_o
);

  wlb_pkg::cfg_t                cfg;
  wlb_pkg::item_ctrl_t          item;
  wlb_pkg::bank_data_t          bank_data;
  logic                         accept;
  logic                         busy;
  logic [wlb_pkg::PIXEL_W-1:0]  px;

  assign stall_o = busy;
  assign accept  = valid_i && !busy;
  assign px      = pixel_i & wlb_pkg::PIXEL_MASK;

  wlb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  wlb_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .cfg_i    (cfg),
    .item_o   (item)
  );

  // Write the pixel into its row bank, read the same column from all banks
  for (genvar b = 0; b < wlb_pkg::NUM_BANKS; b++) begin : g_bank
    wlb_row_mem u_row_mem (
      .clk_i     (clk_i),
      .wr_en_i   (accept && (item.sel == wlb_pkg::SEL_W'(b))),
      .wr_addr_i (item.col),
      .wr_data_i (px),
      .rd_en_i   (accept),
      .rd_addr_i (item.col),
      .rd_data_o (bank_data[b])
    );
  end

  wlb_window u_window (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (accept),
    .pixel_i        (px),
    .item_i         (item),
    .bank_data_i    (bank_data),
    .busy_o         (busy),
    .stall_i        (stall_i),
    .valid_o        (valid_o),
    .top_left_o     (top_left_o),
    .top_mid_o      (top_mid_o),
    .top_right_o    (top_right_o),
    .mid_left_o     (mid_left_o),
    .centre_o       (centre_o),
    .mid_right_o    (mid_right_o),
    .bottom_left_o  (bottom_left_o),
    .bottom_mid_o   (bottom_mid_o),
    .bottom_right_o (bottom_right_o),
    .frame_last_o   (frame_last_o),
    .run_last_o     (run_last_o)
  );

endmodule

>>> rtl/wlb_checker.sv
// Port-level checks of the 3x3 window line buffer, bound to the top level.
`timescale 1ns / 1ps
`include "window_3x3_line_buffer_macros.svh"

module wlb_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          stall_o,
  input  logic                          valid_o,
  input  logic                          stall_i,
  input  logic [wlb_pkg::PIXEL_W-1:0]   top_left_o,
  input  logic [wlb_pkg::PIXEL_W-1:0]   top_mid_o,
  input  logic [wlb_pkg::PIXEL_W-1:0]   top_right_o,
  input  logic [wlb_pkg::PIXEL_W-1:0]   mid_left_o,
  input  logic [wlb_pkg::PIXEL_W-1:0]   centre_o,
  input  logic [wlb_pkg::PIXEL_W-1:0]   mid_right_o,
  input  logic [wlb_pkg::PIXEL_W-1:0]   bottom_left_o,
  input  logic [wlb_pkg::PIXEL_W-1:0]   bottom_mid_o,
  input  logic [wlb_pkg::PIXEL_W-1:0]   bottom_right_o,
  input  logic                          frame_last_o,
  input  logic                          run_last_o
);

  logic [9*wlb_pkg::PIXEL_W+1:0] out_beat;

  assign out_beat = {top_left_o, top_mid_o, top_right_o, mid_left_o, centre_o, mid_right_o,
                     bottom_left_o, bottom_mid_o, bottom_right_o, frame_last_o, run_last_o};

  // Hold a stalled window
  `WLB_ASSERT_NEXT(a_out_hold, valid_o && stall_i, valid_o && $stable(out_beat), "window changed while stalled")

  // Mark the end of a run only on a frame end
  `WLB_ASSERT_NOW(a_run_in_frame, valid_o && run_last_o, frame_last_o, "run_last without frame_last")

  // Push back only when the output is full and held
  `WLB_ASSERT_NOW(a_stall_cause, stall_o, valid_o && stall_i, "input stalled with free output")

  // Keep bits beyond the channels clear in the bottom_right pixel
  `WLB_ASSERT_NOW(a_px_mask, valid_o, (bottom_right_o & ~wlb_pkg::PIXEL_MASK) == '0, "unmasked pixel bits")

endmodule

bind window_3x3_line_buffer wlb_checker u_wlb_checker (.*);
